>>> rtl/core/fct_pkg.sv
`default_nettype none

package fct_pkg;

    // Default coordinate width and fixed plane count
    localparam int COORD_BITS_DEF = 16;
    localparam int PLANE_COUNT    = 6;

    // Plane register layout: nx, ny, nz (Q1.14) and integer offset, 16 bits each
    localparam int PLANE_W   = 64;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 14;

    // Configuration index width (covers indexes beyond the last plane)
    localparam int CFG_IDX_W = 3;

    // Query shape codes
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/fct_cell.sv
`default_nettype none

// One plane of the frustum: holds the plane register and tests each query
// against it in two stages (products, then sum and compare).
module fct_cell #(
    parameter int COORD_BITS = 16,
    parameter int CELL_INDEX = 0,
    parameter int QW         = 7 * COORD_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [fct_pkg::PLANE_W-1:0]         i_cfg_wdata,
    input  wire logic                                i_valid,
    input  wire logic [QW-1:0]                       i_query,
    output logic                                     o_ready,
    output logic                                     o_valid,
    output logic [QW-1:0]                            o_query,
    input  wire logic                                i_ready
);
    import fct_pkg::*;

    localparam int HW = COORD_BITS - 1;
    localparam int PW = COORD_BITS + 16;
    localparam int DW = ((COORD_BITS + 16) > 30 ? (COORD_BITS + 16) : 30) + 3;

    typedef struct packed {
        logic [1:0]                   kind;
        logic                         full;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic [HW-1:0]                rad;
        logic [HW-1:0]                hx;
        logic [HW-1:0]                hy;
        logic [HW-1:0]                hz;
        logic                         ok;
    } t_query;

    logic [PLANE_W-1:0] r_plane;

    t_query q_in;
    t_query r_a_query;
    t_query r_b_query;
    t_query n_b_query;
    logic   r_a_valid;
    logic   r_b_valid;
    logic   a_ready;
    logic   b_ready;

    logic signed [COEF_W-1:0] nrm [3];
    logic [COEF_W:0]          nabs [3];
    logic signed [COORD_BITS-1:0] cen [3];
    logic [HW-1:0]            hlf [3];
    logic signed [PW-1:0]     n_p [3];
    logic [PW-1:0]            n_q [3];
    logic signed [PW-1:0]     r_p [3];
    logic [PW-1:0]            r_q [3];

    logic signed [COEF_W-1:0] off;
    logic [DW-1:0]            dc;
    logic [DW-1:0]            tm;
    logic [DW-1:0]            s_plus;
    logic [DW-1:0]            s_minus;
    logic                     plane_ok;

    assign q_in = t_query'(i_query);

    // Plane register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_we && i_cfg_idx == CFG_IDX_W'(CELL_INDEX)) begin
            r_plane <= i_cfg_wdata;
        end
    end

    // Handshake between the two stages
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_query = QW'(r_b_query);

    // Stage A: n.c products and |n|.h products
    assign cen[0] = q_in.cx;
    assign cen[1] = q_in.cy;
    assign cen[2] = q_in.cz;
    assign hlf[0] = q_in.hx;
    assign hlf[1] = q_in.hy;
    assign hlf[2] = q_in.hz;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nrm[k]  = r_plane[COEF_W*k +: COEF_W];
            nabs[k] = nrm[k][COEF_W-1] ? ((COEF_W+1)'(~nrm[k]) + (COEF_W+1)'(1))
                                       : (COEF_W+1)'(nrm[k]);
            n_p[k]  = PW'(nrm[k]) * PW'(cen[k]);
            n_q[k]  = PW'(nabs[k]) * PW'(hlf[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_query <= q_in;
            r_p       <= n_p;
            r_q       <= n_q;
        end
    end

    // Stage B: distance of the center, margin term, sign tests
    assign off = r_plane[COEF_W*3 +: COEF_W];
    assign dc  = DW'(r_p[0]) + DW'(r_p[1]) + DW'(r_p[2]) + (DW'(off) << FRAC_BITS);

    always_comb begin
        case (r_a_query.kind)
            KIND_BOX:    tm = DW'(r_q[0]) + DW'(r_q[1]) + DW'(r_q[2]);
            KIND_SPHERE: tm = DW'(r_a_query.rad) << FRAC_BITS;
            default:     tm = '0;
        endcase
    end

    assign s_plus  = dc + tm;
    assign s_minus = dc - tm;

    always_comb begin
        case (r_a_query.kind)
            KIND_POINT:  plane_ok = !s_plus[DW-1];
            KIND_SPHERE: plane_ok = r_a_query.full ? !s_minus[DW-1] : !s_plus[DW-1];
            KIND_BOX:    plane_ok = r_a_query.full ? (!s_minus[DW-1] && !s_plus[DW-1])
                                                   : !s_plus[DW-1];
            default:     plane_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_b_query    = r_a_query;
        n_b_query.ok = r_a_query.ok && plane_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b_query <= n_b_query;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/frustum_cull_test.sv
`default_nettype none

// Channel   | Direction | Signals                         | Content
// s_axis    | in        | tvalid tready tdata tuser       | one query
// m_axis    | out       | tvalid tready tdata             | passes flag
// cfg       | in        | i_cfg_we i_cfg_idx i_cfg_wdata  | plane register write
//
// One query per cycle sustained while m_axis accepts results; six plane cells in a chain, two
// register stages each, plus the output register.
// Reset (synchronous, active low) clears all planes to zero and empties the chain.
// A stall on m_axis backs up stage by stage; empty stages keep filling, so
// s_axis_tready drops only once every stage holds an item.
module frustum_cull_test #(
    parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [fct_pkg::PLANE_W-1:0]           i_cfg_wdata,
    // query stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // center_x, center_y, center_z, radius, half_x, half_y, half_z, zero fill
    input  wire logic [((7*COORD_BITS-4+7)/8)*8-1:0]   s_axis_tdata,
    // req_type, full_inside
    input  wire logic [2:0]                            s_axis_tuser,
    // result stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // passes, zero fill
    output logic [7:0]                                 m_axis_tdata
);
    import fct_pkg::*;

    localparam int HW = COORD_BITS - 1;
    localparam int QW = 4 + 3 * COORD_BITS + 4 * HW;

    typedef struct packed {
        logic [1:0]                   kind;
        logic                         full;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic [HW-1:0]                rad;
        logic [HW-1:0]                hx;
        logic [HW-1:0]                hy;
        logic [HW-1:0]                hz;
        logic                         ok;
    } t_query;

    t_query          q_entry;
    t_query          q_last;
    logic            c_valid [PLANE_COUNT+1];
    logic            c_ready [PLANE_COUNT+1];
    logic [QW-1:0]   c_query [PLANE_COUNT+1];

    logic            r_out_valid;
    logic            r_out_pass;
    logic            out_ready;

    // Unpack the input transfer; the running result starts true
    always_comb begin
        q_entry.kind = s_axis_tuser[1:0];
        q_entry.full = s_axis_tuser[2];
        q_entry.cx   = s_axis_tdata[0 +: COORD_BITS];
        q_entry.cy   = s_axis_tdata[COORD_BITS +: COORD_BITS];
        q_entry.cz   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        q_entry.rad  = s_axis_tdata[3*COORD_BITS +: HW];
        q_entry.hx   = s_axis_tdata[3*COORD_BITS + HW +: HW];
        q_entry.hy   = s_axis_tdata[3*COORD_BITS + 2*HW +: HW];
        q_entry.hz   = s_axis_tdata[3*COORD_BITS + 3*HW +: HW];
        q_entry.ok   = 1'b1;
    end

    assign c_valid[0]    = s_axis_tvalid;
    assign c_query[0]    = QW'(q_entry);
    assign s_axis_tready = c_ready[0];

    // Chain of plane cells
    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        fct_cell #(
            .COORD_BITS (COORD_BITS),
            .CELL_INDEX (i),
            .QW         (QW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cfg_we    (i_cfg_we),
            .i_cfg_idx   (i_cfg_idx),
            .i_cfg_wdata (i_cfg_wdata),
            .i_valid     (c_valid[i]),
            .i_query     (c_query[i]),
            .o_ready     (c_ready[i]),
            .o_valid     (c_valid[i+1]),
            .o_query     (c_query[i+1]),
            .i_ready     (c_ready[i+1])
        );
    end

    // Output register
    assign q_last                = t_query'(c_query[PLANE_COUNT]);
    assign out_ready             = !r_out_valid || m_axis_tready;
    assign c_ready[PLANE_COUNT]  = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= c_valid[PLANE_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_pass <= q_last.ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pass};

    // Input backpressure only when the whole chain is full and the output stalls
    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while chain has room");

    // An item leaving the last cell reaches the output register
    a_last_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[PLANE_COUNT] && out_ready) |=> m_axis_tvalid)
        else $error("result lost between last cell and output");

    // A result only goes away after it was taken
    a_out_taken : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without transfer");

    // Nothing is presented right after reset
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

>>> sim/frustum_cull_test_tb.sv
`timescale 1ns / 100ps

module frustum_cull_test_tb;

    import fct_pkg::*;

    localparam int COORD_W        = COORD_BITS_DEF;
    localparam int TDATA_W        = ((7*COORD_W-4+7)/8)*8;
    localparam int IDX_W          = CFG_IDX_W;
    localparam int CFG_SLOTS      = 1 << CFG_IDX_W;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int HOLD_CYCLES    = 150;
    localparam int TAIL_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SPAN_FRUSTUM   = 12000;
    localparam int SPAN_FULL      = 32767;
    localparam int DIR_ROWS       = 13;

    // shape code the package leaves undefined
    localparam logic [1:0] KIND_UNDEF = 2'd3;

    // plane register indexes
    localparam int PLANE_TOP    = 0;
    localparam int PLANE_BOTTOM = 1;
    localparam int PLANE_LEFT   = 2;
    localparam int PLANE_RIGHT  = 3;
    localparam int PLANE_NEAR   = 4;
    localparam int PLANE_FAR    = 5;

    // corner settings for all six planes
    localparam logic [PLANE_W-1:0] PLANES_MAX_POS  = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam logic [PLANE_W-1:0] PLANES_MAX_NEG  = 64'h8000_8000_8000_8000;
    localparam logic [PLANE_W-1:0] PLANES_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum {VERDICT_FAIL, VERDICT_PASS, VERDICT_PREDICT} t_verdict;
    typedef enum {CFG_TILTED, CFG_RANDOM, CFG_MAX_POS, CFG_MAX_NEG, CFG_ALL_ONES} t_cfg_kind;

    typedef struct {
        logic [1:0]         req_type;
        logic               full_inside;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic [14:0]        radius;
        logic [14:0]        half_x;
        logic [14:0]        half_y;
        logic [14:0]        half_z;
    } t_query;

    typedef struct {
        t_query   q;
        t_verdict want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_idx = '0;
    logic [PLANE_W-1:0]   i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // center_x, center_y, center_z, radius, half_x, half_y, half_z, zero fill
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    // req_type, full_inside
    logic [2:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // passes, zero fill
    logic [7:0]           m_axis_tdata;

    // local copy of the plane registers
    logic [PLANE_W-1:0]   plane_copy [PLANE_COUNT];
    bit                   verdict_q [$];
    t_dir_row             dir_rows [DIR_ROWS];
    t_cfg_kind            phase_plan [PHASES] = '{CFG_TILTED, CFG_MAX_POS, CFG_TILTED, CFG_RANDOM,
                                                  CFG_MAX_NEG, CFG_TILTED, CFG_ALL_ONES, CFG_TILTED};

    bit  steady = 1'b0;
    bit  rx_hold_req = 1'b0;
    int  n_errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_passing = 0;
    int  n_settings = 0;
    int  n_backpressure = 0;
    int  quiet_cycles = 0;

    frustum_cull_test DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint plane_coef(logic [PLANE_W-1:0] r, int k);
        return longint'($signed(r[COEF_W*k +: COEF_W]));
    endfunction

    // exact signed distance in Q.14
    function automatic longint plane_distance(logic [PLANE_W-1:0] r, longint p [3]);
        longint d;
        d = plane_coef(r, 3) <<< FRAC_BITS;
        for (int k = 0; k < 3; k++)
            d += plane_coef(r, k) * p[k];
        return d;
    endfunction

    function automatic bit cull_verdict(t_query q);
        longint c [3];
        longint h [3];
        longint pv [3];
        longint nv [3];
        longint rad;
        longint d;
        bit     ok;
        c[0] = q.center_x;
        c[1] = q.center_y;
        c[2] = q.center_z;
        h[0] = q.half_x;
        h[1] = q.half_y;
        h[2] = q.half_z;
        rad  = longint'(q.radius) <<< FRAC_BITS;
        ok   = 1'b1;
        if (q.req_type == KIND_UNDEF)
            return 1'b0;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            case (q.req_type)
                KIND_POINT: begin
                    if (plane_distance(plane_copy[i], c) < 0)
                        ok = 1'b0;
                end
                KIND_SPHERE: begin
                    d = plane_distance(plane_copy[i], c);
                    if (q.full_inside ? (d < rad) : (d < -rad))
                        ok = 1'b0;
                end
                default: begin
                    // positive vertex follows the normal's sign per axis
                    for (int k = 0; k < 3; k++) begin
                        if (plane_coef(plane_copy[i], k) >= 0) begin
                            pv[k] = c[k] + h[k];
                            nv[k] = c[k] - h[k];
                        end else begin
                            pv[k] = c[k] - h[k];
                            nv[k] = c[k] + h[k];
                        end
                    end
                    if (plane_distance(plane_copy[i], pv) < 0)
                        ok = 1'b0;
                    else if (q.full_inside && plane_distance(plane_copy[i], nv) < 0)
                        ok = 1'b0;
                end
            endcase
        end
        return ok;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_dir_row mk_row(logic [1:0] kind, logic full, int x, int y, int z,
                                        int r, int hx, int hy, int hz, t_verdict want);
        t_dir_row row;
        row.q.req_type    = kind;
        row.q.full_inside = full;
        row.q.center_x    = 16'(x);
        row.q.center_y    = 16'(y);
        row.q.center_z    = 16'(z);
        row.q.radius      = 15'(r);
        row.q.half_x      = 15'(hx);
        row.q.half_y      = 15'(hy);
        row.q.half_z      = 15'(hz);
        row.want          = want;
        return row;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int off);
        return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic logic [15:0] draw_coord(int span);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2*span)) - span);
    endfunction

    function automatic logic [14:0] draw_extent(int span);
        if ($urandom_range(0, 7) == 0)
            return 15'($urandom);
        return 15'($urandom_range(0, span/4));
    endfunction

    function automatic t_query draw_query(int span);
        t_query q;
        int     pick;
        pick          = $urandom_range(0, 19);
        q.req_type    = (pick == 0) ? KIND_UNDEF : 2'(pick % 3);
        q.full_inside = 1'($urandom_range(0, 1));
        q.center_x    = draw_coord(span);
        q.center_y    = draw_coord(span);
        q.center_z    = draw_coord(span);
        q.radius      = draw_extent(span);
        q.half_x      = draw_extent(span);
        q.half_y      = draw_extent(span);
        q.half_z      = draw_extent(span);
        return q;
    endfunction

    // box-like frustum with slightly tilted normals, random plane words, or a corner setting
    function automatic void draw_planes(t_cfg_kind kind,
                                        output logic [PLANE_W-1:0] vals [PLANE_COUNT]);
        int n [3];
        int axis;
        int main_mag;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            case (kind)
                CFG_TILTED: begin
                    axis = (i == PLANE_TOP || i == PLANE_BOTTOM) ? 1 :
                           (i == PLANE_LEFT || i == PLANE_RIGHT) ? 0 : 2;
                    for (int k = 0; k < 3; k++)
                        n[k] = int'($urandom_range(0, 6000)) - 3000;
                    main_mag = 16384 - int'($urandom_range(0, 2000));
                    n[axis] = (i == PLANE_TOP || i == PLANE_RIGHT || i == PLANE_FAR)
                              ? -main_mag : main_mag;
                    vals[i] = pack_plane(n[0], n[1], n[2], $urandom_range(2000, 16000));
                end
                CFG_RANDOM:  vals[i] = {$urandom, $urandom};
                CFG_MAX_POS: vals[i] = PLANES_MAX_POS;
                CFG_MAX_NEG: vals[i] = PLANES_MAX_NEG;
                default:     vals[i] = PLANES_ALL_ONES;
            endcase
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("frustum_cull_test_tb: MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // write all planes back to back, plus the unused indexes with junk
    task automatic program_planes(logic [PLANE_W-1:0] vals [PLANE_COUNT]);
        for (int k = 0; k < CFG_SLOTS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= k[IDX_W-1:0];
            i_cfg_wdata <= (k < PLANE_COUNT) ? vals[k] : ~vals[k % PLANE_COUNT];
            @(posedge i_clk);
            if (k < PLANE_COUNT)
                plane_copy[k] = vals[k];
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_query(t_query q, bit passes);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {q.full_inside, q.req_type};
        s_axis_tdata  <= {4'b0, q.half_z, q.half_y, q.half_x, q.radius,
                          q.center_z, q.center_y, q.center_x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdict_q.push_back(passes);
        n_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // at reset all planes are zero, so typed verdicts hold there only
    task automatic run_directed(bit at_reset);
        bit passes;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (at_reset && dir_rows[r].want != VERDICT_PREDICT)
                passes = (dir_rows[r].want == VERDICT_PASS);
            else
                passes = cull_verdict(dir_rows[r].q);
            send_query(dir_rows[r].q, passes);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [PLANE_W-1:0] planes [PLANE_COUNT];
        int                 span;
        t_query             q;

        for (int i = 0; i < PLANE_COUNT; i++)
            plane_copy[i] = '0;

        // extremes, every shape, unused fields, undefined shape
        dir_rows[0]  = mk_row(KIND_POINT, 0, 0, 0, 0, 0, 0, 0, 0, VERDICT_PASS);
        dir_rows[1]  = mk_row(KIND_POINT, 1, 32767, 32767, 32767, 0, 0, 0, 0, VERDICT_PASS);
        dir_rows[2]  = mk_row(KIND_POINT, 1, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                              VERDICT_PASS);
        dir_rows[3]  = mk_row(KIND_SPHERE, 1, 0, 0, 0, 0, 32767, 0, 0, VERDICT_PASS);
        dir_rows[4]  = mk_row(KIND_SPHERE, 1, 100, -100, 7, 32767, 0, 0, 0, VERDICT_FAIL);
        dir_rows[5]  = mk_row(KIND_SPHERE, 0, -32768, 32767, 0, 32767, 0, 0, 0, VERDICT_PASS);
        dir_rows[6]  = mk_row(KIND_BOX, 1, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                              VERDICT_PASS);
        dir_rows[7]  = mk_row(KIND_BOX, 0, 32767, 32767, 32767, 0, 0, 0, 0, VERDICT_PASS);
        dir_rows[8]  = mk_row(KIND_UNDEF, 0, 0, 0, 0, 0, 0, 0, 0, VERDICT_FAIL);
        dir_rows[9]  = mk_row(KIND_UNDEF, 1, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                              VERDICT_FAIL);
        dir_rows[10] = mk_row(KIND_BOX, 1, 21845, -21846, 1000, 0, 10922, 21845, 300,
                              VERDICT_PREDICT);
        dir_rows[11] = mk_row(KIND_SPHERE, 0, 900, -1200, 500, 400, 0, 0, 0, VERDICT_PREDICT);
        dir_rows[12] = mk_row(KIND_POINT, 0, 999, -999, 40, 0, 0, 0, 0, VERDICT_PREDICT);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows against the reset planes
        run_directed(1'b1);
        drain_results();

        // same rows against a hand-built frustum; near plane has a zero normal
        planes[PLANE_TOP]    = pack_plane(0, -16384, 0, 1000);
        planes[PLANE_BOTTOM] = pack_plane(0, 16384, 0, 1000);
        planes[PLANE_LEFT]   = pack_plane(16384, 0, 2000, 1000);
        planes[PLANE_RIGHT]  = pack_plane(-16384, 0, 0, 1000);
        planes[PLANE_NEAR]   = pack_plane(0, 0, 0, 5);
        planes[PLANE_FAR]    = pack_plane(-3000, 0, -16384, 30000);
        program_planes(planes);
        run_directed(1'b0);

        // random phases, one plane setting each; planes stay fixed within a phase
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            draw_planes(phase_plan[p], planes);
            program_planes(planes);
            span = (phase_plan[p] == CFG_TILTED) ? SPAN_FRUSTUM : SPAN_FULL;
            steady = (p == 3 || p == 6);
            if (p == 2)
                rx_hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                q = draw_query(span);
                send_query(q, cull_verdict(q));
            end
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        $display("frustum_cull_test_tb: %0d queries over %0d plane settings, %0d results checked",
                 n_sent, n_settings, n_checked);
        $display("frustum_cull_test_tb: %0d passed the cull, %0d cycles of input back-pressure",
                 n_passing, n_backpressure);
        if (n_errors == 0)
            $display("frustum_cull_test_tb: done, clean");
        else
            $display("frustum_cull_test_tb: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random gaps, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_side
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            // a transfer happened at this edge
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result check
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        bit want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result passes=%0b with none outstanding",
                                          m_axis_tdata[0]));
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want)
                    report_mismatch($sformatf("result %0d: passes=%0b, predicted %0b",
                                              n_checked, m_axis_tdata[0], want));
                if (want)
                    n_passing++;
                n_checked++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog on quiet cycles
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if (s_axis_tvalid && !s_axis_tready)
            n_backpressure++;
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("frustum_cull_test_tb: timeout, no transfer for %0d cycles", quiet_cycles);
            $display("frustum_cull_test_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> sim.f
rtl/core/fct_pkg.sv
rtl/core/fct_cell.sv
rtl/core/frustum_cull_test.sv
sim/frustum_cull_test_tb.sv
